// ===== design/ramdac_extended_register_port_assert.svh =====
// assertion macros for the ramdac extended register port
// expects clk and rst_n in the scope of the including module
`ifndef RAMDAC_EXTENDED_REGISTER_PORT_ASSERT_SVH
`define RAMDAC_EXTENDED_REGISTER_PORT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RDXP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define RDXP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/rdxp_pkg.sv =====
// shared types, codes and constants for the ramdac extended register port
// no dependencies
package rdxp_pkg;

  localparam int EXT_REG_DEPTH_DEF = 256;
  localparam int UNLOCK_READS_DEF  = 4;
  localparam int UNLOCK_CNT_W      = 3;
  localparam int IDX_W             = 8;

  // access kinds
  localparam logic FUNC_RD = 1'b0;
  localparam logic FUNC_WR = 1'b1;

  // register select codes, {rs2_line, reg_select}
  localparam logic [2:0] RS_DATA    = 3'd0;
  localparam logic [2:0] RS_IDX_RD  = 3'd1;
  localparam logic [2:0] RS_MASK    = 3'd2;
  localparam logic [2:0] RS_IDX_WR  = 3'd3;
  localparam logic [2:0] RS_CMD     = 3'd6;

  // extended register indexes
  localparam logic [7:0] IDX_DAC_WIDTH  = 8'h08;
  localparam logic [7:0] IDX_ID0        = 8'h09;
  localparam logic [7:0] IDX_ID1        = 8'h0a;
  localparam logic [7:0] IDX_ID2        = 8'h0b;
  localparam logic [7:0] IDX_ID3        = 8'h0c;
  localparam logic [7:0] IDX_MASK_LO    = 8'h0d;
  localparam logic [7:0] IDX_MASK_MID   = 8'h0e;
  localparam logic [7:0] IDX_MASK_HI    = 8'h0f;
  localparam logic [7:0] IDX_TRUE_COLOR = 8'h10;

  localparam logic [7:0] ID_BYTE0 = 8'h53;
  localparam logic [7:0] ID_BYTE1 = 8'h3a;
  localparam logic [7:0] ID_BYTE2 = 8'hb1;
  localparam logic [7:0] ID_BYTE3 = 8'h41;

  // command byte bits
  localparam int CMD_EXT_BIT  = 4;
  localparam int CMD_B5       = 5;
  localparam int CMD_B6       = 6;
  localparam int CMD_B7       = 7;
  localparam logic [7:0] CMD_NO_DEPTH = 8'hff;

  localparam logic [23:0] MASK_RESET = 24'hffffff;

  // colour depth codes
  localparam logic [2:0] DEPTH_8  = 3'd0;
  localparam logic [2:0] DEPTH_15 = 3'd1;
  localparam logic [2:0] DEPTH_16 = 3'd2;
  localparam logic [2:0] DEPTH_24 = 3'd3;
  localparam logic [2:0] DEPTH_32 = 3'd4;

  typedef struct packed {
    logic       func;
    logic [1:0] reg_select;
    logic       rs2_line;
    logic [7:0] write_data;
    logic [7:0] vga_read_data;
    logic [7:0] vga_dac_mask;
  } in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        forward_write;
    logic [2:0]  depth_code;
    logic        depth_changed;
    logic        dac_width_update;
    logic        dac_eight_bit;
    logic [23:0] pixel_mask_out;
  } out_t;

  // register file access, read and write never in the same cycle
  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] addr;
    logic [7:0]       wr_data;
  } mem_req_t;

  function automatic logic [2:0] depth_calc(input logic [7:0] cmd, input logic tc_bit);
    logic [2:0] d;
    if (cmd[CMD_B7]) begin
      d = cmd[CMD_B6] ? DEPTH_16 : DEPTH_15;
    end else if (cmd[CMD_B6]) begin
      if (tc_bit) d = DEPTH_32;
      else d = cmd[CMD_B5] ? DEPTH_24 : DEPTH_32;
    end else begin
      d = DEPTH_8;
    end
    return d;
  endfunction

endpackage

// ===== design/rdxp_ext_file.sv =====
// extended register file: synchronous ram with registered read
// entries never written since reset read as zero through per-entry valid bits
// depends on rdxp_pkg
module rdxp_ext_file #(
  parameter int EXT_REG_DEPTH = rdxp_pkg::EXT_REG_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rdxp_pkg::mem_req_t req,
  output logic [7:0]         rd_data
);

  localparam int AW = $clog2(EXT_REG_DEPTH);

  logic [7:0]               ram [EXT_REG_DEPTH];
  logic [EXT_REG_DEPTH-1:0] vld_r;
  logic [7:0]               q_r;
  logic                     q_vld_r;
  logic [AW-1:0]            addr;

  assign addr = req.addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (req.wr_en) ram[addr] <= req.wr_data;
    if (req.rd_en) q_r <= ram[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) vld_r[addr] <= 1'b1;
      if (req.rd_en) q_vld_r <= vld_r[addr];
    end
  end

  assign rd_data = q_vld_r ? q_r : 8'h00;

endmodule

// ===== design/ramdac_extended_register_port.sv =====
// ramdac extended register port, top level
// depends on rdxp_pkg, rdxp_ext_file and ramdac_extended_register_port_assert.svh
//
//   channel | direction | handshake             | payload
//   in      | into      | in_valid / in_ready   | in_data  (rdxp_pkg::in_t)
//   out     | out of    | out_valid / out_ready | out_data (rdxp_pkg::out_t)
//   cfg     | into      | cfg_valid / cfg_ready | cfg_data (rs2 decode enable)
//
// each access has a transfer cycle, which reads the register file at the current
// index, and an exec state, which decodes, writes back and loads the output register.
// the exec state waits while the output register still holds an untaken result.
// synchronous reset; the register file needs no clearing pass (valid bits).
// in_ready and cfg_ready are low while reset is held; cfg_ready is high otherwise.
`include "ramdac_extended_register_port_assert.svh"

module ramdac_extended_register_port #(
  parameter int EXT_REG_DEPTH = rdxp_pkg::EXT_REG_DEPTH_DEF,
  parameter int UNLOCK_READS  = rdxp_pkg::UNLOCK_READS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rdxp_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rdxp_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_data
);

  localparam int CW = rdxp_pkg::UNLOCK_CNT_W;
  localparam logic [CW-1:0] UNLOCK_MAX = CW'(UNLOCK_READS);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic          state_r;
  logic          rs2_mode_r;
  logic [CW-1:0] unlock_cnt_r, unlock_cnt_nxt;
  logic [7:0]    cmd_r, cmd_nxt;
  logic [7:0]    index_r, index_nxt;
  logic [23:0]   mask_r, mask_nxt;
  logic [2:0]    depth_r, depth_nxt;
  logic          tc_bit_r, tc_bit_nxt;
  rdxp_pkg::in_t  in_q_r;
  rdxp_pkg::out_t out_r, out_nxt;
  logic          out_valid_r;

  rdxp_pkg::mem_req_t mem_req;
  logic [7:0]    mem_rd_data;
  logic          fire;
  logic          ext;
  logic [2:0]    rs;
  logic [7:0]    wbyte;
  logic [7:0]    mbyte;
  logic [7:0]    idx_rd;
  logic          do_cmd_wr, do_idx_wr, do_index_wr;
  logic          mem_wr;

  assign in_ready  = rst_n && (state_r == S_IDLE);
  assign cfg_ready = rst_n;
  assign fire      = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign ext       = cmd_r[rdxp_pkg::CMD_EXT_BIT];
  assign rs        = {in_q_r.rs2_line, in_q_r.reg_select};
  assign wbyte     = in_q_r.write_data;
  assign mbyte     = in_q_r.write_data & in_q_r.vga_dac_mask;

  // indexed read: fixed id bytes and mask bytes override the file
  always_comb begin
    case (index_r)
      rdxp_pkg::IDX_ID0:      idx_rd = rdxp_pkg::ID_BYTE0;
      rdxp_pkg::IDX_ID1:      idx_rd = rdxp_pkg::ID_BYTE1;
      rdxp_pkg::IDX_ID2:      idx_rd = rdxp_pkg::ID_BYTE2;
      rdxp_pkg::IDX_ID3:      idx_rd = rdxp_pkg::ID_BYTE3;
      rdxp_pkg::IDX_MASK_LO:  idx_rd = mask_r[7:0];
      rdxp_pkg::IDX_MASK_MID: idx_rd = mask_r[15:8];
      rdxp_pkg::IDX_MASK_HI:  idx_rd = mask_r[23:16];
      default:                idx_rd = mem_rd_data;
    endcase
  end

  always_comb begin
    unlock_cnt_nxt = unlock_cnt_r;
    cmd_nxt        = cmd_r;
    index_nxt      = index_r;
    mask_nxt       = mask_r;
    depth_nxt      = depth_r;
    tc_bit_nxt     = tc_bit_r;
    out_nxt        = '0;
    do_cmd_wr      = 1'b0;
    do_idx_wr      = 1'b0;
    do_index_wr    = 1'b0;
    mem_wr         = 1'b0;

    if (in_q_r.func == rdxp_pkg::FUNC_WR) begin
      if (rs2_mode_r) begin
        case (rs)
          rdxp_pkg::RS_DATA:   if (ext) do_idx_wr = 1'b1; else out_nxt.forward_write = 1'b1;
          rdxp_pkg::RS_MASK:   if (ext) do_cmd_wr = 1'b1; else out_nxt.forward_write = 1'b1;
          rdxp_pkg::RS_IDX_WR: if (ext) do_index_wr = 1'b1; else out_nxt.forward_write = 1'b1;
          rdxp_pkg::RS_CMD:    do_cmd_wr = 1'b1;
          default:             out_nxt.forward_write = 1'b1;
        endcase
      end else begin
        case (rs[1:0])
          rdxp_pkg::RS_MASK[1:0]: begin
            if (unlock_cnt_r == UNLOCK_MAX || ext) do_cmd_wr = 1'b1;
            else out_nxt.forward_write = 1'b1;
          end
          rdxp_pkg::RS_IDX_WR[1:0]: if (ext) do_index_wr = 1'b1; else out_nxt.forward_write = 1'b1;
          rdxp_pkg::RS_DATA[1:0]:   if (ext) do_idx_wr = 1'b1; else out_nxt.forward_write = 1'b1;
          default:                  out_nxt.forward_write = 1'b1;
        endcase
        unlock_cnt_nxt = '0;
      end
    end else begin
      out_nxt.read_data = in_q_r.vga_read_data;
      if (rs2_mode_r) begin
        case (rs)
          rdxp_pkg::RS_DATA:   if (ext) out_nxt.read_data = idx_rd;
          rdxp_pkg::RS_IDX_RD: if (ext) out_nxt.read_data = index_r;
          rdxp_pkg::RS_MASK:   if (ext) out_nxt.read_data = cmd_r;
          rdxp_pkg::RS_CMD:    out_nxt.read_data = cmd_r;
          default:             ;
        endcase
      end else begin
        case (rs[1:0])
          rdxp_pkg::RS_MASK[1:0]: begin
            if (unlock_cnt_r >= UNLOCK_MAX) out_nxt.read_data = cmd_r;
            else unlock_cnt_nxt = unlock_cnt_r + 1'b1;
          end
          rdxp_pkg::RS_DATA[1:0]: begin
            if (ext) out_nxt.read_data = idx_rd;
            unlock_cnt_nxt = '0;
          end
          rdxp_pkg::RS_IDX_RD[1:0]: begin
            if (ext) out_nxt.read_data = index_r;
            unlock_cnt_nxt = '0;
          end
          default: unlock_cnt_nxt = '0;
        endcase
      end
    end

    if (do_cmd_wr) begin
      cmd_nxt = wbyte;
      if (wbyte != rdxp_pkg::CMD_NO_DEPTH) depth_nxt = rdxp_pkg::depth_calc(wbyte, tc_bit_r);
    end
    if (do_index_wr) index_nxt = wbyte;
    if (do_idx_wr) begin
      case (index_r)
        rdxp_pkg::IDX_DAC_WIDTH: begin
          mem_wr                   = 1'b1;
          out_nxt.dac_width_update = 1'b1;
          out_nxt.dac_eight_bit    = wbyte[0];
        end
        rdxp_pkg::IDX_MASK_LO:  mask_nxt = {16'h0000, mbyte};
        rdxp_pkg::IDX_MASK_MID: mask_nxt = mask_r | {8'h00, mbyte, 8'h00};
        rdxp_pkg::IDX_MASK_HI:  mask_nxt = mask_r | {mbyte, 16'h0000};
        rdxp_pkg::IDX_TRUE_COLOR: begin
          mem_wr     = 1'b1;
          tc_bit_nxt = wbyte[0];
          depth_nxt  = rdxp_pkg::depth_calc(cmd_r, wbyte[0]);
        end
        default: mem_wr = 1'b1;
      endcase
    end

    out_nxt.depth_code     = depth_nxt;
    out_nxt.depth_changed  = (depth_nxt != depth_r);
    out_nxt.pixel_mask_out = mask_nxt;
  end

  // read at the transfer, write back in the decode cycle; the fsm keeps them apart
  always_comb begin
    mem_req.rd_en   = in_valid && in_ready;
    mem_req.wr_en   = fire && mem_wr;
    mem_req.addr    = index_r;
    mem_req.wr_data = wbyte;
  end

  rdxp_ext_file #(
    .EXT_REG_DEPTH(EXT_REG_DEPTH)
  ) u_ext_file (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (mem_req),
    .rd_data(mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rs2_mode_r   <= 1'b0;
      unlock_cnt_r <= '0;
      cmd_r        <= 8'h00;
      index_r      <= 8'h00;
      mask_r       <= rdxp_pkg::MASK_RESET;
      depth_r      <= rdxp_pkg::DEPTH_8;
      tc_bit_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) rs2_mode_r <= cfg_data;
      case (state_r)
        S_IDLE:  if (in_valid) state_r <= S_EXEC;
        S_EXEC:  if (fire) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
      if (fire) begin
        unlock_cnt_r <= unlock_cnt_nxt;
        cmd_r        <= cmd_nxt;
        index_r      <= index_nxt;
        mask_r       <= mask_nxt;
        depth_r      <= depth_nxt;
        tc_bit_r     <= tc_bit_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_q_r <= in_data;
    if (fire) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `RDXP_ASSERT_NOW(a_no_take_in_exec, state_r == S_EXEC, !in_ready, "input taken mid-access")
  `RDXP_ASSERT_NOW(a_wr_only_on_fire, mem_req.wr_en, fire && !mem_req.rd_en, "file write outside decode")
  `RDXP_ASSERT_NOW(a_unlock_sat, 1'b1, unlock_cnt_r <= UNLOCK_MAX, "unlock count past saturation")
  `RDXP_ASSERT_NEXT(a_fire_loads_out, fire, out_valid_r && state_r == S_IDLE, "result not loaded")
  `RDXP_ASSERT_NOW(a_depth_legal, 1'b1, depth_r <= rdxp_pkg::DEPTH_32, "illegal depth code")

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for ramdac_extended_register_port
// needs rdxp_pkg and the block's rtl; keeps its own copy of the register state
// and checks every result transfer against it, in order
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rdxp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 6;
  localparam int RANDOM_ITEMS_PER_PHASE = 190;
  localparam logic [UNLOCK_CNT_W-1:0] UNLOCK_LIMIT = UNLOCK_CNT_W'(UNLOCK_READS_DEF);

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  // shadow of the block's state
  logic rs2_decode;
  logic [UNLOCK_CNT_W-1:0] unlock_reads_seen;
  logic [7:0] command;
  logic [7:0] index_reg;
  logic [7:0] ext_file [EXT_REG_DEPTH_DEF];
  logic [23:0] mask_shadow;
  logic [2:0] colour_depth;

  out_t replies_due[$];
  int accesses_sent = 0;
  int replies_checked = 0;
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_off = 1'b0;
  int unsigned cycles_run = 0;

  ramdac_extended_register_port #(
    .EXT_REG_DEPTH(EXT_REG_DEPTH_DEF),
    .UNLOCK_READS (UNLOCK_READS_DEF)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [2:0] depth_for(input logic [7:0] c, input logic tc);
    if (c[CMD_B7]) return c[CMD_B6] ? DEPTH_16 : DEPTH_15;
    if (!c[CMD_B6]) return DEPTH_8;
    return (c[CMD_B5] && !tc) ? DEPTH_24 : DEPTH_32;
  endfunction

  function automatic void load_command(input logic [7:0] v);
    command = v;
    if (v != CMD_NO_DEPTH) colour_depth = depth_for(v, ext_file[IDX_TRUE_COLOR][0]);
  endfunction

  function automatic void file_write(input logic [7:0] v, input logic [7:0] dmask,
                                     inout out_t r);
    logic [7:0] masked;
    masked = v & dmask;
    case (index_reg)
      IDX_DAC_WIDTH: begin
        ext_file[IDX_DAC_WIDTH] = v;
        r.dac_width_update = 1'b1;
        r.dac_eight_bit = v[0];
      end
      IDX_MASK_LO: mask_shadow = {16'h0000, masked};
      // upper mask bytes accumulate, nothing clears them short of the low byte write
      IDX_MASK_MID: mask_shadow[15:8] = mask_shadow[15:8] | masked;
      IDX_MASK_HI: mask_shadow[23:16] = mask_shadow[23:16] | masked;
      IDX_TRUE_COLOR: begin
        ext_file[IDX_TRUE_COLOR] = v;
        colour_depth = depth_for(command, v[0]);
      end
      default: ext_file[index_reg] = v;
    endcase
  endfunction

  function automatic logic [7:0] file_read();
    logic [7:0] v;
    case (index_reg)
      IDX_ID0: v = ID_BYTE0;
      IDX_ID1: v = ID_BYTE1;
      IDX_ID2: v = ID_BYTE2;
      IDX_ID3: v = ID_BYTE3;
      IDX_MASK_LO: v = mask_shadow[7:0];
      IDX_MASK_MID: v = mask_shadow[15:8];
      IDX_MASK_HI: v = mask_shadow[23:16];
      default: v = ext_file[index_reg];
    endcase
    return v;
  endfunction

  function automatic out_t predict_port_access(input in_t a);
    out_t r;
    logic ext;
    logic [2:0] prior_depth;
    logic [2:0] sel;
    r = '0;
    ext = command[CMD_EXT_BIT];
    prior_depth = colour_depth;
    sel = rs2_decode ? {a.rs2_line, a.reg_select} : {1'b0, a.reg_select};
    if (a.func == FUNC_WR) begin
      case (sel)
        RS_DATA: if (ext) file_write(a.write_data, a.vga_dac_mask, r);
                 else r.forward_write = 1'b1;
        RS_MASK: begin
          if (ext || (!rs2_decode && unlock_reads_seen == UNLOCK_LIMIT))
            load_command(a.write_data);
          else
            r.forward_write = 1'b1;
        end
        RS_IDX_WR: if (ext) index_reg = a.write_data;
                   else r.forward_write = 1'b1;
        RS_CMD: load_command(a.write_data);
        default: r.forward_write = 1'b1;
      endcase
      if (!rs2_decode) unlock_reads_seen = '0;
    end else begin
      r.read_data = a.vga_read_data;
      case (sel)
        RS_DATA: if (ext) r.read_data = file_read();
        RS_IDX_RD: if (ext) r.read_data = index_reg;
        RS_MASK: begin
          if (rs2_decode) begin
            if (ext) r.read_data = command;
          end else if (unlock_reads_seen >= UNLOCK_LIMIT) begin
            r.read_data = command;
          end else begin
            unlock_reads_seen = unlock_reads_seen + 3'd1;
          end
        end
        RS_CMD: r.read_data = command;
        default: ;
      endcase
      if (!rs2_decode && sel != RS_MASK) unlock_reads_seen = '0;
    end
    r.depth_code = colour_depth;
    r.depth_changed = colour_depth != prior_depth;
    r.pixel_mask_out = mask_shadow;
    return r;
  endfunction

  function automatic in_t random_access();
    logic [31:0] raw;
    raw = $urandom;
    return raw[$bits(in_t)-1:0];
  endfunction

  // rs2 line only matters in three-bit decode, so it is left random otherwise
  function automatic in_t make_access(input logic f, input logic [2:0] sel,
                                      input logic [7:0] wd);
    in_t a;
    a = random_access();
    a.func = f;
    a.reg_select = sel[1:0];
    a.rs2_line = rs2_decode ? sel[2] : 1'($urandom);
    a.write_data = wd;
    return a;
  endfunction

  function automatic logic [7:0] pick_index();
    case ($urandom_range(3))
      0, 1: return 8'($urandom_range(IDX_DAC_WIDTH, IDX_TRUE_COLOR));
      2: return 8'($urandom_range(31));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_command();
    logic [7:0] c;
    c = 8'($urandom);
    if ($urandom_range(3) != 0) c[CMD_EXT_BIT] = 1'b1;
    if ($urandom_range(9) == 0) c = CMD_NO_DEPTH;
    return c;
  endfunction

  task automatic send_access(input in_t a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    replies_due.push_back(predict_port_access(a));
    accesses_sent++;
  endtask

  task automatic access(input logic f, input logic [2:0] sel, input logic [7:0] wd);
    send_access(make_access(f, sel, wd));
  endtask

  task automatic wait_for_replies();
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_decode(input logic rs2);
    wait_for_replies();
    cfg_valid <= 1'b1;
    cfg_data <= rs2;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    rs2_decode = rs2;
  endtask

  task automatic check_reply(input out_t got);
    out_t want;
    if (replies_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("%0t: result %h with no access outstanding", $time, got);
    end else begin
      want = replies_due.pop_front();
      if (got.read_data !== want.read_data || got.forward_write !== want.forward_write ||
          got.depth_code !== want.depth_code || got.depth_changed !== want.depth_changed ||
          got.dac_width_update !== want.dac_width_update ||
          got.dac_eight_bit !== want.dac_eight_bit ||
          got.pixel_mask_out !== want.pixel_mask_out) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result %0d expected rd %h fwd %b depth %0d chg %b wupd %b w8 %b mask %h",
                   $time, replies_checked, want.read_data, want.forward_write,
                   want.depth_code, want.depth_changed, want.dac_width_update,
                   want.dac_eight_bit, want.pixel_mask_out);
          $display("    actual rd %h fwd %b depth %0d chg %b wupd %b w8 %b mask %h",
                   got.read_data, got.forward_write, got.depth_code, got.depth_changed,
                   got.dac_width_update, got.dac_eight_bit, got.pixel_mask_out);
        end
      end
    end
    replies_checked++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_reply(out_data);
    out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // long receiver hold-off, counted here so the sender keeps offering meanwhile
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
        hold_req = 1'b0;
      end
    end
  end

  initial begin
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("ramdac_extended_register_port: mismatch");
    $finish;
  end

  task automatic test_legacy_forwarding();
    in_t a;
    a = make_access(FUNC_RD, RS_DATA, 8'h00);
    a.vga_read_data = 8'hff;
    send_access(a);
    a = make_access(FUNC_RD, RS_IDX_RD, 8'hff);
    a.vga_read_data = 8'h00;
    send_access(a);
    access(FUNC_WR, RS_IDX_WR, 8'hff);
  endtask

  // mask port reads saturate the unlock count, then a mask write lands in the command byte
  task automatic test_hidden_unlock();
    repeat (UNLOCK_READS_DEF + 1) access(FUNC_RD, RS_MASK, 8'h00);
    access(FUNC_WR, RS_MASK, 8'h10);
  endtask

  task automatic test_indexed_registers();
    in_t a;
    access(FUNC_WR, RS_IDX_WR, IDX_ID0);
    access(FUNC_RD, RS_DATA, 8'h00);
    access(FUNC_WR, RS_IDX_WR, IDX_MASK_LO);
    a = make_access(FUNC_WR, RS_DATA, 8'h00);
    a.vga_dac_mask = 8'hff;
    send_access(a);
    access(FUNC_WR, RS_IDX_WR, IDX_MASK_HI);
    a = make_access(FUNC_WR, RS_DATA, 8'hff);
    a.vga_dac_mask = 8'h0f;
    send_access(a);
    access(FUNC_RD, RS_DATA, 8'h00);
    access(FUNC_WR, RS_IDX_WR, IDX_DAC_WIDTH);
    access(FUNC_WR, RS_DATA, 8'hff);
    access(FUNC_WR, RS_IDX_WR, IDX_TRUE_COLOR);
    access(FUNC_WR, RS_DATA, 8'h01);
    // depth through 16, 32 with true colour set, unchanged by the no-depth code, back to 8
    access(FUNC_WR, RS_MASK, 8'hd0);
    access(FUNC_WR, RS_MASK, 8'h50);
    access(FUNC_WR, RS_MASK, CMD_NO_DEPTH);
    access(FUNC_WR, RS_MASK, 8'h10);
  endtask

  task automatic test_three_bit_decode();
    access(FUNC_RD, RS_CMD, 8'h00);
    access(FUNC_WR, RS_CMD, 8'h00);
    access(FUNC_WR, RS_DATA, 8'h5a);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    repeat (24) send_access(random_access());
  endtask

  task automatic random_sequence();
    int n;
    case ($urandom_range(9))
      0, 1: begin
        if (rs2_decode && $urandom_range(1) == 1) begin
          access(FUNC_WR, RS_CMD, pick_command());
        end else begin
          if (!rs2_decode) repeat (UNLOCK_READS_DEF) access(FUNC_RD, RS_MASK, 8'h00);
          access(FUNC_WR, RS_MASK, pick_command());
        end
      end
      2, 3, 4: begin
        access(FUNC_WR, RS_IDX_WR, pick_index());
        n = $urandom_range(1, 3);
        repeat (n) access(1'($urandom), RS_DATA, 8'($urandom));
      end
      5: begin
        access(FUNC_RD, RS_IDX_RD, 8'h00);
        access(FUNC_RD, rs2_decode ? RS_CMD : RS_MASK, 8'h00);
      end
      6: begin
        // a run of mask reads shorter than the unlock count, then a random access
        n = $urandom_range(1, UNLOCK_READS_DEF - 1);
        repeat (n) access(FUNC_RD, RS_MASK, 8'h00);
        send_access(random_access());
      end
      7: repeat (UNLOCK_READS_DEF + 2) access(FUNC_RD, RS_MASK, 8'h00);
      default: begin
        n = $urandom_range(1, 3);
        repeat (n) send_access(random_access());
      end
    endcase
  endtask

  task automatic test_random_traffic(input int items, input int idle, input int stall);
    int start_count;
    start_count = accesses_sent;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    while (accesses_sent - start_count < items) random_sequence();
  endtask

  initial begin
    rs2_decode = 1'b0;
    unlock_reads_seen = '0;
    command = '0;
    index_reg = '0;
    foreach (ext_file[i]) ext_file[i] = '0;
    mask_shadow = MASK_RESET;
    colour_depth = DEPTH_8;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_decode(1'b0);
    test_legacy_forwarding();
    test_hidden_unlock();
    test_indexed_registers();
    set_decode(1'b1);
    test_three_bit_decode();
    test_backpressure();
    for (int p = 0; p < 8; p++) begin
      set_decode(1'(p % 2));
      case (p / 2)
        0: test_random_traffic(RANDOM_ITEMS_PER_PHASE, 0, 0);
        1: test_random_traffic(RANDOM_ITEMS_PER_PHASE, 57, 0);
        2: test_random_traffic(RANDOM_ITEMS_PER_PHASE, 0, 57);
        default: test_random_traffic(RANDOM_ITEMS_PER_PHASE, 6, 6);
      endcase
    end

    wait_for_replies();
    if (mismatches == 0 && replies_due.size() == 0)
      $display("ramdac_extended_register_port: match");
    else
      $display("ramdac_extended_register_port: mismatch");
    $finish;
  end

endmodule
